// ===== sv/sbas_pkg.sv =====
package sbas_pkg;

  localparam int unsigned ProjDim    = 256;
  localparam int unsigned ChunkLen   = 32;
  localparam int unsigned ChunkCount = ProjDim / ChunkLen;
  localparam int unsigned LaneCount  = 8;
  localparam int unsigned RawW       = 17;
  localparam int unsigned LaneSumW   = 14;

  // fp32 of 1.2533141373155003f / 256, exact power-of-two scaling.
  localparam logic [31:0] CoefBits = 32'h3BA06C99;
  localparam logic [31:0] CanonNan = 32'h7FC00000;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_SCALE = 2'd1,
    REQ_SCORE = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  // Decoded fp32 operand: class flags plus normalized 24-bit significand.
  typedef struct packed {
    logic        sign;
    logic        is_zero;
    logic        is_inf;
    logic        is_nan;
    logic signed [10:0] exp;
    logic [23:0] man;
  } fp_t;

  // Product before rounding: 48-bit significand with its exponent.
  typedef struct packed {
    logic        sign;
    logic        is_zero;
    logic        is_inf;
    logic        is_nan;
    logic signed [11:0] exp;
    logic [47:0] man;
  } fprod_t;

  function automatic logic [4:0] lzc24(input logic [23:0] v);
    logic [4:0] n;
    logic       hit;
    n   = 5'd0;
    hit = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (!hit && v[i]) begin
        n   = 5'(23 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic fp_t fp_unpack(input logic [31:0] b);
    fp_t        r;
    logic [4:0] lz;
    r.sign    = b[31];
    r.is_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    r.is_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    r.is_zero = (b[30:0] == 31'd0);
    if (b[30:23] == 8'd0) begin
      lz    = lzc24({1'b0, b[22:0]});
      r.man = {1'b0, b[22:0]} << lz;
      r.exp = 11'sd1 - 11'sd127 - 11'(signed'({1'b0, lz}));
    end else begin
      lz    = 5'd0;
      r.man = {1'b1, b[22:0]};
      r.exp = 11'(signed'({3'b0, b[30:23]})) - 11'sd127;
    end
    return r;
  endfunction

  // Rounds a product (value = man * 2^(exp-47)) to fp32, nearest even.
  function automatic logic [31:0] fp_round(input fprod_t p);
    logic [47:0]        m;
    logic signed [11:0] e;
    logic [49:0]        ext;
    logic [23:0]        sig;
    logic               g, st;
    logic [24:0]        rs;
    logic signed [11:0] sh;
    logic [31:0]        res;
    m = p.man;
    e = p.exp;
    if (!m[47]) begin
      m = m << 1;
      e = e - 12'sd1;
    end
    // m[47] is now the leading one, value = 1.m * 2^e
    if (p.is_nan || (p.is_inf && p.is_zero)) begin
      res = CanonNan;
    end else if (p.is_inf) begin
      res = {p.sign, 8'hFF, 23'd0};
    end else if (p.is_zero) begin
      res = {p.sign, 31'd0};
    end else begin
      sh = 12'sd0;
      if (e < -12'sd126) sh = -12'sd126 - e;
      if (sh > 12'sd30) sh = 12'sd30;
      ext = {m, 2'b00} >> sh[4:0];
      st  = 1'b0;
      for (int i = 0; i < 31; i++) begin
        if (i < int'(sh) && m[i]) st = 1'b1;
      end
      sig = ext[49:26];
      g   = ext[25];
      st  = st | (ext[24:0] != 25'd0);
      rs  = {1'b0, sig} + 25'(g && (st || sig[0]));
      if (sh != 12'sd0) begin
        // subnormal range; a carry into bit 23 makes the smallest normal
        res = {p.sign, 7'd0, rs[23], rs[22:0]};
      end else begin
        if (rs[24]) begin
          e  = e + 12'sd1;
          rs = rs >> 1;
        end
        if (e > 12'sd127) res = {p.sign, 8'hFF, 23'd0};
        else res = {p.sign, 8'(e + 12'sd127), rs[22:0]};
      end
    end
    return res;
  endfunction

  function automatic fprod_t fp_mul_core(input fp_t a, input fp_t b);
    fprod_t r;
    r.sign    = a.sign ^ b.sign;
    r.is_nan  = a.is_nan || b.is_nan;
    r.is_inf  = a.is_inf || b.is_inf;
    r.is_zero = a.is_zero || b.is_zero;
    r.exp     = 12'(a.exp) + 12'(b.exp) + 12'sd1;
    r.man     = a.man * b.man;
    return r;
  endfunction

endpackage

// ===== sv/sbas_if.sv =====
interface sbas_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [2:0]  chunk_index;
  logic [63:0] vector_word0;
  logic [63:0] vector_word1;
  logic [63:0] vector_word2;
  logic [63:0] vector_word3;
  logic [15:0] key_norm_bf16;
  logic [31:0] query_scale_bits;

  modport source (output valid, req_type, chunk_index, vector_word0, vector_word1,
                  vector_word2, vector_word3, key_norm_bf16, query_scale_bits,
                  input ready);
  modport sink (input valid, req_type, chunk_index, vector_word0, vector_word1,
                vector_word2, vector_word3, key_norm_bf16, query_scale_bits,
                output ready);
endinterface

interface sbas_res_if;
  logic               valid;
  logic               ready;
  logic [31:0]        score_bits;
  logic signed [16:0] raw_sign_dot;

  modport source (output valid, score_bits, raw_sign_dot, input ready);
  modport sink (input valid, score_bits, raw_sign_dot, output ready);
endinterface

// ===== sv/sbas_lane.sv =====
// One lane: signed sum of one 32-element chunk under its sign bits.
module sbas_lane (
  input  logic [255:0]                       q_i,
  input  logic [31:0]                        bits_i,
  output logic signed [sbas_pkg::LaneSumW-1:0] sum_o
);

  always_comb begin
    logic signed [sbas_pkg::LaneSumW-1:0] t [32];
    logic signed [sbas_pkg::LaneSumW-1:0] q;
    for (int b = 0; b < 32; b++) begin
      q    = sbas_pkg::LaneSumW'(signed'(q_i[b*8 +: 8]));
      t[b] = bits_i[b] ? q : -q;
    end
    // Pairwise adder tree, five levels deep.
    for (int w = 16; w > 0; w = w >> 1) begin
      for (int i = 0; i < w; i++) t[i] = t[2*i] + t[2*i+1];
    end
    sum_o = t[0];
  end

endmodule

// ===== sv/sbas_fmul.sv =====
// Two-stage fp32 multiplier: register after the product, then round.
module sbas_fmul (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] p_o
);

  sbas_pkg::fprod_t prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) prod_q <= sbas_pkg::fp_mul_core(sbas_pkg::fp_unpack(a_i),
                                              sbas_pkg::fp_unpack(b_i));
  end

  assign p_o = sbas_pkg::fp_round(prod_q);

endmodule

// ===== sv/sign_bit_int8_attention_score_core.sv =====
// Channel  | Dir | Contents
// req      | in  | req_type, chunk_index, vector_word0..3, key_norm_bf16, query_scale_bits
// res      | out | score_bits, raw_sign_dot (one per score transaction)
//
// One transaction is accepted per cycle while the output is not stalled. A
// score passes through registered stages: lane sums, lane merge plus the c*norm
// product, its rounding, the product with the scale, its rounding, and the product with
// float(raw), which is rounded on the output. The pipeline advances only when
// its last stage is empty or being taken, so a stalled output holds every stage.
// Reset clears the valid bits and the query scale; query bytes are undefined
// until loaded.
module sign_bit_int8_attention_score_core (
  input  logic clk_i,
  input  logic rst_ni,
  sbas_req_if.sink   req_i,
  sbas_res_if.source res_o
);

  localparam int unsigned Lanes  = sbas_pkg::LaneCount;
  localparam int unsigned Stages = 6;

  logic [255:0] query_q [Lanes];
  logic [31:0]  scale_q;

  logic [Stages-1:0] vld_q;
  logic              adv;
  logic              take;

  // The last stage's register doubles as the output register.
  assign adv   = !vld_q[Stages-1] || res_o.ready;
  assign req_i.ready = adv;
  assign take  = req_i.valid && adv;

  // Query storage: one 32-byte row per lane.
  always_ff @(posedge clk_i) begin
    if (take && req_i.req_type == sbas_pkg::REQ_LOAD) begin
      query_q[req_i.chunk_index] <= {req_i.vector_word3, req_i.vector_word2,
                                     req_i.vector_word1, req_i.vector_word0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= '0;
    end else if (take && req_i.req_type == sbas_pkg::REQ_SCALE) begin
      scale_q <= req_i.query_scale_bits;
    end
  end

  // Each score carries the scale that held when it was accepted, so a later
  // scale update does not reach scores still in flight.
  logic [31:0] scale_p_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      scale_p_q[0] <= scale_q;
      scale_p_q[1] <= scale_p_q[0];
      scale_p_q[2] <= scale_p_q[1];
    end
  end

  // Stage 0: lane sums.
  logic [255:0] key_bits;
  logic signed [sbas_pkg::LaneSumW-1:0] lane_sum [Lanes];
  logic signed [sbas_pkg::LaneSumW-1:0] lane_q   [Lanes];
  logic [31:0] norm_s0_q;

  assign key_bits = {req_i.vector_word3, req_i.vector_word2,
                     req_i.vector_word1, req_i.vector_word0};

  for (genvar l = 0; l < Lanes; l++) begin : g_lane
    sbas_lane u_lane (
      .q_i   (query_q[l]),
      .bits_i(key_bits[l*32 +: 32]),
      .sum_o (lane_sum[l])
    );
    always_ff @(posedge clk_i) begin
      if (adv) lane_q[l] <= lane_sum[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) norm_s0_q <= {req_i.key_norm_bf16, 16'h0000};
  end

  // Stage 1: merge lanes and convert raw to fp32.
  logic signed [sbas_pkg::RawW-1:0] raw_merge;
  logic signed [sbas_pkg::RawW-1:0] raw_q [1:Stages-1];
  logic [31:0] rawf_q [1:Stages-2];
  logic [31:0] rawf;

  always_comb begin
    raw_merge = '0;
    for (int l = 0; l < Lanes; l++) raw_merge = raw_merge + sbas_pkg::RawW'(lane_q[l]);
  end

  always_comb begin
    logic [16:0] mag;
    logic [4:0]  lz;
    logic [23:0] m;
    mag = raw_merge[16] ? 17'(-raw_merge) : 17'(raw_merge);
    lz  = sbas_pkg::lzc24({7'd0, mag});
    m   = {7'd0, mag} << lz;
    if (mag == 17'd0) rawf = 32'd0;
    else rawf = {raw_merge[16], 8'(8'd127 + 8'd23 - {3'd0, lz}), m[22:0]};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      raw_q[1]  <= raw_merge;
      rawf_q[1] <= rawf;
      for (int s = 2; s < Stages; s++) raw_q[s] <= raw_q[s-1];
      for (int s = 2; s < Stages - 1; s++) rawf_q[s] <= rawf_q[s-1];
    end
  end

  // Stages 1-2: c*norm; 3-4: *scale; 5: *float(raw), rounded on the output.
  logic [31:0] t1, t2, score;

  sbas_fmul u_m1 (.clk_i(clk_i), .en_i(adv), .a_i(sbas_pkg::CoefBits),
                  .b_i(norm_s0_q), .p_o(t1));

  logic [31:0] t1_q;
  always_ff @(posedge clk_i) if (adv) t1_q <= t1;

  sbas_fmul u_m2 (.clk_i(clk_i), .en_i(adv), .a_i(t1_q), .b_i(scale_p_q[2]), .p_o(t2));

  logic [31:0] t2_q;
  always_ff @(posedge clk_i) if (adv) t2_q <= t2;

  sbas_fmul u_m3 (.clk_i(clk_i), .en_i(adv), .a_i(t2_q), .b_i(rawf_q[Stages-2]),
                  .p_o(score));

  // Valid pipeline; stage 0 is the cycle after acceptance of a score.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Stages-2:0], take && req_i.req_type == sbas_pkg::REQ_SCORE};
    end
  end

  // The multiplier's product register sits in stage 5; rounding is the
  // output logic of the last stage.
  assign res_o.valid        = vld_q[Stages-1];
  assign res_o.score_bits   = score;
  assign res_o.raw_sign_dot = raw_q[Stages-1];

endmodule
